[sv/atb_pkg.sv]
// Package: shared types, constants and helpers for the affine transform builder.
`default_nettype none
package atb_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW = $clog2(CordicSteps + 1);

  localparam logic [2:0] FuncIdent = 3'd0;
  localparam logic [2:0] FuncScale = 3'd1;
  localparam logic [2:0] FuncTrans = 3'd2;
  localparam logic [2:0] FuncRot = 3'd3;
  localparam logic [2:0] FuncPoint = 3'd4;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  localparam logic signed [31:0] OneQ16 = 32'sd65536;
  localparam logic signed [27:0] Deg90 = 28'sd5898240;
  localparam logic signed [27:0] Deg180 = 28'sd11796480;
  localparam logic signed [27:0] Deg360 = 28'sd23592960;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [2:0] {
    OpNone = 3'd0,
    OpIdent = 3'd1,
    OpScale = 3'd2,
    OpTrans = 3'd3,
    OpLoad = 3'd4,
    OpCordic = 3'd5,
    OpMac = 3'd6,
    OpWrite = 3'd7
  } op_e;

  typedef struct packed {
    op_e op;
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] term;
    logic       out_slot;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
  } stat_t;

  function automatic logic signed [27:0] atan_tab(input logic [4:0] i);
    logic signed [27:0] r;
    begin
      unique case (i)
        5'd0: r = 28'sd2949120;  5'd1: r = 28'sd1740967;
        5'd2: r = 28'sd919879;   5'd3: r = 28'sd466945;
        5'd4: r = 28'sd234379;   5'd5: r = 28'sd117304;
        5'd6: r = 28'sd58666;    5'd7: r = 28'sd29335;
        5'd8: r = 28'sd14668;    5'd9: r = 28'sd7334;
        5'd10: r = 28'sd3667;    5'd11: r = 28'sd1833;
        5'd12: r = 28'sd917;     5'd13: r = 28'sd458;
        5'd14: r = 28'sd229;     5'd15: r = 28'sd115;
        5'd16: r = 28'sd57;      5'd17: r = 28'sd29;
        5'd18: r = 28'sd14;      5'd19: r = 28'sd7;
        5'd20: r = 28'sd4;       5'd21: r = 28'sd2;
        5'd22: r = 28'sd1;
        default: r = 28'sd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    begin
      if (v > 50'sd2147483647) r = 32'sh7fffffff;
      else if (v < -50'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

endpackage
`default_nettype wire

[sv/atb_ctrl.sv]
// Controller: sequences identity, scale, translate, rotate and point commands.
`default_nettype none
module atb_ctrl import atb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [2:0] func_i,
  input  wire logic [1:0] axis_i,
  input  wire stat_t      stat_i,
  input  wire logic       out_busy_i,
  output cmd_t            cmd_o,
  output logic            busy_o,
  output logic            out_push_o
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StCord = 6'b000010,
    StRot  = 6'b000100,
    StPt   = 6'b001000,
    StWait = 6'b010000,
    StOne  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] func_q, func_d;
  logic [1:0] axis_q, axis_d;
  logic [1:0] col_q, col_d;
  logic [1:0] term_q, term_d;
  logic [1:0] row_q, row_d;

  always_comb begin
    state_d = state_q;
    func_d = func_q;
    axis_d = axis_q;
    col_d = col_q;
    term_d = term_q;
    row_d = row_q;
    cmd_o = '{op: OpNone, row: row_q, col: col_q, term: term_q, out_slot: 1'b0};
    out_push_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          func_d = func_i;
          axis_d = axis_i;
          col_d = '0;
          term_d = '0;
          row_d = '0;
          cmd_o.op = OpLoad;
          priority if (func_i == FuncRot) state_d = StCord;
          else if (func_i == FuncPoint) state_d = StPt;
          else state_d = StOne;
        end
      end
      StOne: begin
        priority if (func_q == FuncIdent) cmd_o.op = OpIdent;
        else if (func_q == FuncScale) cmd_o.op = OpScale;
        else if (func_q == FuncTrans) cmd_o.op = OpTrans;
        else cmd_o.op = OpNone;
        state_d = StIdle;
      end
      StCord: begin
        cmd_o.op = OpCordic;
        if (stat_i.cordic_done) begin
          if (axis_q == 2'd3) state_d = StIdle;
          else state_d = StRot;
        end
      end
      StRot: begin
        // term 0/1 accumulate row a, term 2/3 row b, then write both
        cmd_o.row = axis_q;
        if (term_q == 2'd3 && row_q == 2'd1) begin
          cmd_o.op = OpWrite;
          row_d = '0;
          term_d = '0;
          col_d = col_q + 2'd1;
          if (col_q == 2'd3) state_d = StIdle;
        end else begin
          cmd_o.op = OpMac;
          if (term_q == 2'd3) row_d = 2'd1;
          else term_d = term_q + 2'd1;
        end
      end
      StPt: begin
        cmd_o.op = OpMac;
        cmd_o.row = row_q;
        if (term_q == 2'd2) begin
          term_d = '0;
          cmd_o.out_slot = 1'b1;
          if (row_q == 2'd2) state_d = StWait;
          else row_d = row_q + 2'd1;
        end else term_d = term_q + 2'd1;
      end
      StWait: begin
        if (!out_busy_i) begin
          out_push_o = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      func_q <= '0;
      axis_q <= '0;
      col_q <= '0;
      term_q <= '0;
      row_q <= '0;
    end else begin
      state_q <= state_d;
      func_q <= func_d;
      axis_q <= axis_d;
      col_q <= col_d;
      term_q <= term_d;
      row_q <= row_d;
    end
  end

endmodule
`default_nettype wire

[sv/atb_dp.sv]
// Datapath: matrix registers, CORDIC and a shared 32x32 multiply-accumulate.
`default_nettype none
module atb_dp import atb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  input  wire logic signed [31:0] vec_x_i,
  input  wire logic signed [31:0] vec_y_i,
  input  wire logic signed [31:0] vec_z_i,
  input  wire logic signed [25:0] angle_i,
  input  wire logic               out_push_i,
  input  wire logic               out_ready_i,
  output stat_t                   stat_o,
  output logic                    out_valid_o,
  output logic [95:0]             out_data_o
);

  logic signed [31:0] m_q [12];
  logic signed [31:0] v_q [3];
  logic signed [33:0] cx_q, cy_q;
  logic signed [27:0] cz_q;
  logic [StepW-1:0]   step_q;
  logic               flip_q;
  logic signed [31:0] cos_q, sin_q;
  logic signed [49:0] hi_q;
  logic [17:0]        lo_q;
  logic signed [31:0] res_q [3];
  logic signed [31:0] out_q [3];
  logic signed [31:0] ra_q;
  logic               ov_q;
  logic               rot_q;

  // angle reduction into (-180,180], then +-90 fold
  logic signed [27:0] red1, red2, fold;
  logic               fflip;
  always_comb begin
    red1 = {{2{angle_i[25]}}, angle_i};
    priority if (red1 > Deg180) red2 = red1 - Deg360;
    else if (red1 <= -Deg180) red2 = red1 + Deg360;
    else red2 = red1;
    fflip = 1'b1;
    priority if (red2 > Deg90) fold = red2 - Deg180;
    else if (red2 < -Deg90) fold = red2 + Deg180;
    else begin
      fold = red2;
      fflip = 1'b0;
    end
  end

  // CORDIC step
  logic signed [33:0] dx, dy;
  logic signed [27:0] at;
  logic [4:0]         sidx;
  assign sidx = 5'(step_q);
  assign dx = cy_q >>> sidx;
  assign dy = cx_q >>> sidx;
  assign at = atan_tab(sidx);

  logic signed [33:0] xr, yr;
  assign xr = (cx_q + 34'sd8192) >>> 14;
  assign yr = (cy_q + 34'sd8192) >>> 14;

  // rotation: row a index, row b index
  logic [1:0] ria, rib;
  always_comb begin
    unique case (cmd_i.row)
      AxisX: begin ria = 2'd1; rib = 2'd2; end
      AxisY: begin ria = 2'd2; rib = 2'd0; end
      default: begin ria = 2'd0; rib = 2'd1; end
    endcase
  end

  // multiplier operand select
  logic signed [31:0] ma, mb;
  logic [3:0] ia, ib;
  always_comb begin
    ia = {ria, 2'b00} + {2'b00, cmd_i.col};
    ib = {rib, 2'b00} + {2'b00, cmd_i.col};
    ma = '0;
    mb = '0;
    if (cmd_i.op == OpMac) begin
      unique case (cmd_i.term)
        2'd0: begin ma = m_q[{cmd_i.row, 2'b00}]; mb = v_q[0]; end
        2'd1: begin ma = m_q[{cmd_i.row, 2'b01}]; mb = v_q[1]; end
        2'd2: begin ma = m_q[{cmd_i.row, 2'b10}]; mb = v_q[2]; end
        default: begin ma = '0; mb = '0; end
      endcase
    end
  end

  // rotation mac operands
  logic signed [31:0] rma, rmb;
  logic               rot_mode;
  assign rot_mode = (cmd_i.op == OpMac) && rot_q;
  always_comb begin
    unique case (cmd_i.term)
      2'd0: begin rma = cos_q;  rmb = m_q[ia]; end
      2'd1: begin rma = -sin_q; rmb = m_q[ib]; end
      2'd2: begin rma = sin_q;  rmb = m_q[ia]; end
      default: begin rma = cos_q; rmb = m_q[ib]; end
    endcase
  end

  logic signed [63:0] prod;
  assign prod = rot_mode ? (rma * rmb) : (ma * mb);

  logic signed [49:0] hsum;
  logic [17:0]        lsum;
  logic signed [31:0] fin;
  assign hsum = hi_q + 50'(prod >>> 16);
  assign lsum = lo_q + {2'b00, prod[15:0]};
  assign fin = sat32(hsum + 50'(signed'({1'b0, 18'(lsum + 18'd32768)}) >>> 16));

  logic signed [31:0] ra_fin;
  logic signed [31:0] acc_fin;
  assign acc_fin = sat32(hi_q + 50'(signed'({1'b0, 18'(lo_q + 18'd32768)}) >>> 16));
  assign ra_fin = acc_fin;

  logic signed [63:0] sprod [3];
  for (genvar r = 0; r < 3; r++) begin : g_sc
    assign sprod[r] = m_q[r * 5] * v_q[r];
  end

  assign stat_o.cordic_done = (cmd_i.op == OpCordic) && (step_q == StepW'(CordicSteps));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 12; k++) m_q[k] <= (k % 5 == 0) ? OneQ16 : 32'sd0;
      ov_q <= 1'b0;
      rot_q <= 1'b0;
      step_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OpIdent: for (int k = 0; k < 12; k++) m_q[k] <= (k % 5 == 0) ? OneQ16 : 32'sd0;
        OpScale: for (int r = 0; r < 3; r++)
          m_q[r * 5] <= sat32(50'(sprod[r] >>> 16) +
                        50'(signed'({1'b0, 18'({2'b00, sprod[r][15:0]} + 18'd32768)}) >>> 16));
        OpTrans: for (int r = 0; r < 3; r++)
          m_q[r * 4 + 3] <= sat32(50'(m_q[r * 4 + 3]) + 50'(v_q[r]));
        OpWrite: begin
          m_q[ia] <= ra_q;
          m_q[ib] <= fin;
          rot_q <= 1'b1;
        end
        default: ;
      endcase
      if (cmd_i.op == OpLoad) begin
        step_q <= '0;
        rot_q <= 1'b0;
      end else if (cmd_i.op == OpCordic) begin
        if (step_q != StepW'(CordicSteps)) step_q <= step_q + 1'b1;
        rot_q <= 1'b1;
      end
      if (out_push_i) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpLoad: begin
        v_q[0] <= vec_x_i;
        v_q[1] <= vec_y_i;
        v_q[2] <= vec_z_i;
        cx_q <= CordicGain;
        cy_q <= '0;
        cz_q <= fold;
        flip_q <= fflip;
        hi_q <= '0;
        lo_q <= '0;
      end
      OpCordic: begin
        if (step_q != StepW'(CordicSteps)) begin
          if (!cz_q[27]) begin
            cx_q <= cx_q - dx; cy_q <= cy_q + dy; cz_q <= cz_q - at;
          end else begin
            cx_q <= cx_q + dx; cy_q <= cy_q - dy; cz_q <= cz_q + at;
          end
        end
        cos_q <= flip_q ? -xr[31:0] : xr[31:0];
        sin_q <= flip_q ? -yr[31:0] : yr[31:0];
        hi_q <= '0;
        lo_q <= '0;
      end
      OpMac: begin
        if (rot_mode && cmd_i.term == 2'd1) begin
          ra_q <= fin;
          hi_q <= '0;
          lo_q <= '0;
        end else if (!rot_mode && cmd_i.out_slot) begin
          res_q[cmd_i.row] <= sat32(hsum + 50'(m_q[{cmd_i.row, 2'b11}]) +
            50'(signed'({1'b0, 18'(lsum + 18'd32768)}) >>> 16));
          hi_q <= '0;
          lo_q <= '0;
        end else begin
          hi_q <= hsum;
          lo_q <= lsum;
        end
      end
      OpWrite: begin
        hi_q <= '0;
        lo_q <= '0;
      end
      default: ;
    endcase
    // result register holds the transfer while the next point is computed
    if (out_push_i) begin
      out_q[0] <= res_q[0];
      out_q[1] <= res_q[1];
      out_q[2] <= res_q[2];
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o = {out_q[2], out_q[1], out_q[0]};

  logic unused;
  assign unused = ^{ra_fin, ria};

endmodule
`default_nettype wire

[sv/affine_transform_builder.sv]
// Top level: 3D affine transform builder with Q16.16 matrix and CORDIC rotation.
// Identity, scale and translate load the operands, then update the matrix; unknown commands
// leave it. Rotate loads, runs 16 CORDIC steps, then 4 columns of multiply-accumulates with a
// write each, skipping the columns for an unknown axis. Point transform loads, accumulates each
// row, then waits to push; one item in flight at a time, as input is held off while busy; a
// stalled result holds a point. Reset loads the identity matrix and empties output.
`default_nettype none
module affine_transform_builder import atb_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // vec_x, vec_y, vec_z, angle[25:0], zeros
  input  wire logic [4:0]   s_axis_tuser,  // func[2:0], axis[1:0]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata   // out_x, out_y, out_z
);

  cmd_t  cmd;
  stat_t stat;
  logic  busy, push, start;

  assign s_axis_tready = !busy;
  assign start = s_axis_tvalid && s_axis_tready;

  atb_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .func_i(s_axis_tuser[2:0]),
    .axis_i(s_axis_tuser[4:3]), .stat_i(stat), .out_busy_i(m_axis_tvalid && !m_axis_tready),
    .cmd_o(cmd), .busy_o(busy), .out_push_o(push)
  );

  atb_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .vec_x_i(s_axis_tdata[31:0]), .vec_y_i(s_axis_tdata[63:32]),
    .vec_z_i(s_axis_tdata[95:64]), .angle_i(s_axis_tdata[121:96]),
    .out_push_i(push), .out_ready_i(m_axis_tready), .stat_o(stat),
    .out_valid_o(m_axis_tvalid), .out_data_o(m_axis_tdata)
  );

  logic unused;
  assign unused = ^s_axis_tdata[127:122];

endmodule
`default_nettype wire
